// ===== design/hsv2rgb_pkg.sv =====
package hsv2rgb_pkg;

   // full-scale hue level
   localparam int MAX_LEVEL = 255;

   localparam int LVL_W   = 8;
   localparam int COLOR_W = 8;
   localparam int Q_W     = 9;
   localparam int Q_ONE   = 256;

   // remainder and sector arithmetic
   localparam int MW    = $clog2(MAX_LEVEL + 1);
   localparam int X_W   = LVL_W + 3;
   localparam int SEC_W = 3;

   // s*r products and the weights 256*M - s*r
   localparam int SP_W = Q_W + MW;
   // v times weight
   localparam int PR_W = Q_W + SP_W;
   // 255*v*w / 65536, at most 255*M
   localparam int B_W  = 8 + MW;

   // exact reciprocal of MAX_LEVEL for values below 256*M
   localparam int RECIP_SH = 8 + 2 * MW;
   localparam longint unsigned RECIP =
      ((64'd1 << RECIP_SH) + MAX_LEVEL - 1) / MAX_LEVEL;
   localparam int K_W  = RECIP_SH - MW + 2;
   localparam int QP_W = B_W + K_W;

   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_SATURATION = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_BRIGHTNESS = 1'b1;

   localparam logic [Q_W-1:0] SAT_RESET    = 9'd205;
   localparam logic [Q_W-1:0] BRIGHT_RESET = 9'd205;

   localparam logic [SEC_W-1:0] SEC_RED     = 3'd0;
   localparam logic [SEC_W-1:0] SEC_YELLOW  = 3'd1;
   localparam logic [SEC_W-1:0] SEC_GREEN   = 3'd2;
   localparam logic [SEC_W-1:0] SEC_CYAN    = 3'd3;
   localparam logic [SEC_W-1:0] SEC_BLUE    = 3'd4;
   localparam logic [SEC_W-1:0] SEC_MAGENTA = 3'd5;
   localparam logic [SEC_W-1:0] SEC_WRAP    = 3'd6;

   typedef struct packed {
      logic [SEC_W-1:0] sector;
      logic [MW-1:0]    rem;
   } sector_type;

   typedef logic [2:0][PR_W-1:0]    chan_prod_type;
   typedef logic [2:0][COLOR_W-1:0] rgb_type;

endpackage

// ===== design/hsv2rgb_if.sv =====
interface hsv2rgb_req_if import hsv2rgb_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [LVL_W-1:0] level;

   modport source (output valid, output level, input ready);
   modport sink (input valid, input level, output ready);
endinterface

interface hsv2rgb_rsp_if import hsv2rgb_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [COLOR_W-1:0] red;
   logic [COLOR_W-1:0] green;
   logic [COLOR_W-1:0] blue;

   modport source (output valid, output red, output green, output blue, input ready);
   modport sink (input valid, input red, input green, input blue, output ready);
endinterface

// ===== design/hsv_to_rgb_converter.sv =====
// Hue level to RGB converter. Each req beat carries a hue level (clamped to MAX_LEVEL);
// each rsp beat carries red, green and blue as floor(255*intensity) of the HSV color
// with the programmed saturation (csr index 0) and brightness (csr index 1), both Q1.8
// with 256 as 1.0 and larger values treated as 1.0. One level is accepted per clock unless
// backpressure has filled every stage. The datapath has six register stages (sector split,
// saturation products, brightness multiply, scaling by 255, reciprocal multiply for the
// divide by MAX_LEVEL, output register), the first loaded at the accepting edge and the
// last driving rsp. Each stage holds its own beat under backpressure, so bubbles close up
// while the output waits.
// Write the csr registers only when no beat is in flight.
module hsv_to_rgb_converter import hsv2rgb_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   hsv2rgb_req_if.sink          req_bus,
   hsv2rgb_rsp_if.source        rsp_bus,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [Q_W-1:0]       csr_wdata
);

   logic [Q_W-1:0] sat_ff, sat_in, bright_ff, bright_in;
   logic [Q_W-1:0] sat_use, bright_use;

   logic          sec_valid, sec_ready;
   sector_type    sec_data;
   logic          mix_valid, mix_ready;
   chan_prod_type mix_data;
   rgb_type       rgb;

   always_comb begin
      sat_in    = sat_ff;
      bright_in = bright_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_SATURATION: sat_in    = csr_wdata;
            CSR_BRIGHTNESS: bright_in = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sat_ff    <= SAT_RESET;
         bright_ff <= BRIGHT_RESET;
      end else begin
         sat_ff    <= sat_in;
         bright_ff <= bright_in;
      end
   end

   assign sat_use    = (sat_ff > Q_W'(Q_ONE)) ? Q_W'(Q_ONE) : sat_ff;
   assign bright_use = (bright_ff > Q_W'(Q_ONE)) ? Q_W'(Q_ONE) : bright_ff;

   hsv2rgb_sector u_sector (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_bus.valid),
      .in_ready  (req_bus.ready),
      .in_level  (req_bus.level),
      .out_valid (sec_valid),
      .out_ready (sec_ready),
      .out_data  (sec_data)
   );

   hsv2rgb_blend u_blend (
      .clock     (clock),
      .reset     (reset),
      .sat       (sat_use),
      .bright    (bright_use),
      .in_valid  (sec_valid),
      .in_ready  (sec_ready),
      .in_data   (sec_data),
      .out_valid (mix_valid),
      .out_ready (mix_ready),
      .out_data  (mix_data)
   );

   hsv2rgb_scale u_scale (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (mix_valid),
      .in_ready  (mix_ready),
      .in_data   (mix_data),
      .out_valid (rsp_bus.valid),
      .out_ready (rsp_bus.ready),
      .out_data  (rgb)
   );

   assign rsp_bus.red   = rgb[0];
   assign rsp_bus.green = rgb[1];
   assign rsp_bus.blue  = rgb[2];

endmodule

// ===== design/hsv2rgb_sector.sv =====
module hsv2rgb_sector import hsv2rgb_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [LVL_W-1:0] in_level,
   output logic             out_valid,
   input  logic             out_ready,
   output sector_type       out_data
);

   logic             valid_ff, valid_in;
   sector_type       data_ff, data_in;
   logic [LVL_W-1:0] level_c;
   logic [X_W-1:0]   x;
   logic [X_W-1:0]   rem_x;
   logic [SEC_W-1:0] count;

   always_comb begin
      level_c = (32'(in_level) > MAX_LEVEL) ? LVL_W'(MAX_LEVEL) : in_level;
      x       = X_W'(level_c) * X_W'(6);
      // sector is the number of multiples of M not above x
      count   = '0;
      for (int k = 1; k <= 6; k++) begin
         if (32'(x) >= k * MAX_LEVEL) begin
            count = count + SEC_W'(1);
         end
      end
      rem_x = x - X_W'(32'(count) * MAX_LEVEL);
      if (count == SEC_WRAP) begin
         data_in.sector = SEC_RED;
         data_in.rem    = '0;
      end else begin
         data_in.sector = count;
         data_in.rem    = MW'(rem_x);
      end
   end

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// ===== design/hsv2rgb_blend.sv =====
module hsv2rgb_blend import hsv2rgb_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic [Q_W-1:0] sat,
   input  logic [Q_W-1:0] bright,
   input  logic           in_valid,
   output logic           in_ready,
   input  sector_type     in_data,
   output logic           out_valid,
   input  logic           out_ready,
   output chan_prod_type  out_data
);

   typedef struct packed {
      logic [SEC_W-1:0] sector;
      logic [SP_W-1:0]  sq;
      logic [SP_W-1:0]  st;
      logic [SP_W-1:0]  sp;
   } shade_type;

   localparam logic [SP_W-1:0] W_FULL = SP_W'(Q_ONE * MAX_LEVEL);

   logic          v2_ff, v2_in, v3_ff, v3_in;
   logic          rdy2, rdy3;
   shade_type     s2_ff, s2_in;
   chan_prod_type p3_ff, p3_in;
   logic [MW-1:0] m_rem;
   logic [SP_W-1:0] wv, wp, wq, wt;
   logic [2:0][SP_W-1:0] w;

   // stage 2: saturation products
   always_comb begin
      m_rem         = MW'(MAX_LEVEL) - in_data.rem;
      s2_in.sector  = in_data.sector;
      s2_in.sq      = SP_W'(sat) * SP_W'(in_data.rem);
      s2_in.st      = SP_W'(sat) * SP_W'(m_rem);
      s2_in.sp      = SP_W'(sat) * SP_W'(MAX_LEVEL);
   end

   // stage 3: per-channel weight, scaled by brightness
   always_comb begin
      wv = W_FULL;
      wp = W_FULL - s2_ff.sp;
      wq = W_FULL - s2_ff.sq;
      wt = W_FULL - s2_ff.st;
      case (s2_ff.sector)
         SEC_RED: begin
            w[0] = wv; w[1] = wt; w[2] = wp;
         end
         SEC_YELLOW: begin
            w[0] = wq; w[1] = wv; w[2] = wp;
         end
         SEC_GREEN: begin
            w[0] = wp; w[1] = wv; w[2] = wt;
         end
         SEC_CYAN: begin
            w[0] = wp; w[1] = wq; w[2] = wv;
         end
         SEC_BLUE: begin
            w[0] = wt; w[1] = wp; w[2] = wv;
         end
         default: begin
            w[0] = wv; w[1] = wp; w[2] = wq;
         end
      endcase
      for (int i = 0; i < 3; i++) begin
         p3_in[i] = PR_W'(bright) * PR_W'(w[i]);
      end
   end

   assign rdy3     = !v3_ff || out_ready;
   assign rdy2     = !v2_ff || rdy3;
   assign in_ready = rdy2;
   assign v2_in    = rdy2 ? in_valid : v2_ff;
   assign v3_in    = rdy3 ? v2_ff : v3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v2_ff <= v2_in;
         v3_ff <= v3_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy2 && in_valid) begin
         s2_ff <= s2_in;
      end
      if (rdy3 && v2_ff) begin
         p3_ff <= p3_in;
      end
   end

   assign out_valid = v3_ff;
   assign out_data  = p3_ff;

endmodule

// ===== design/hsv2rgb_scale.sv =====
module hsv2rgb_scale import hsv2rgb_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   output logic          in_ready,
   input  chan_prod_type in_data,
   output logic          out_valid,
   input  logic          out_ready,
   output rgb_type       out_data
);

   localparam int A_W  = PR_W + 8;
   localparam int QF_W = QP_W - RECIP_SH;
   localparam logic [QF_W-1:0] QF_MAX = QF_W'((1 << COLOR_W) - 1);

   logic v4_ff, v4_in, v5_ff, v5_in, v6_ff, v6_in;
   logic rdy4, rdy5, rdy6;
   logic [2:0][B_W-1:0]  b4_ff, b4_in;
   logic [2:0][QP_W-1:0] q5_ff, q5_in;
   rgb_type              c6_ff, c6_in;
   logic [2:0][A_W-1:0]  a;
   logic [2:0][QF_W-1:0] qf;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         // 255*prod / 65536
         a[i]     = (A_W'(in_data[i]) << 8) - A_W'(in_data[i]);
         b4_in[i] = B_W'(a[i] >> 16);
         // divide by MAX_LEVEL through its reciprocal
         q5_in[i] = QP_W'(b4_ff[i]) * QP_W'(RECIP);
         qf[i]    = QF_W'(q5_ff[i] >> RECIP_SH);
         c6_in[i] = (qf[i] > QF_MAX) ? '1 : COLOR_W'(qf[i]);
      end
   end

   assign rdy6     = !v6_ff || out_ready;
   assign rdy5     = !v5_ff || rdy6;
   assign rdy4     = !v4_ff || rdy5;
   assign in_ready = rdy4;
   assign v4_in    = rdy4 ? in_valid : v4_ff;
   assign v5_in    = rdy5 ? v4_ff : v5_ff;
   assign v6_in    = rdy6 ? v5_ff : v6_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
      end else begin
         v4_ff <= v4_in;
         v5_ff <= v5_in;
         v6_ff <= v6_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy4 && in_valid) begin
         b4_ff <= b4_in;
      end
      if (rdy5 && v4_ff) begin
         q5_ff <= q5_in;
      end
      if (rdy6 && v5_ff) begin
         c6_ff <= c6_in;
      end
   end

   assign out_valid = v6_ff;
   assign out_data  = c6_ff;

endmodule

// ===== design/hsv2rgb_checker.sv =====
module hsv2rgb_checker import hsv2rgb_pkg::*; (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [COLOR_W-1:0] rsp_red,
   input logic [COLOR_W-1:0] rsp_green,
   input logic [COLOR_W-1:0] rsp_blue
);

   // pipeline comes out of reset empty
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp beat valid right after reset");

   // a taken output frees every stage back to the input
   a_ready_chain: assert property (@(posedge clock) disable iff (reset)
      rsp_ready |-> req_ready)
      else $error("req stalled while rsp is taken");

   // input only stalls when a result is waiting
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid)
      else $error("req stalled with no rsp beat pending");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable({rsp_red, rsp_green, rsp_blue}))
      else $error("stalled rsp beat changed or dropped");

endmodule

bind hsv_to_rgb_converter hsv2rgb_checker u_hsv2rgb_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_bus.valid),
   .req_ready (req_bus.ready),
   .rsp_valid (rsp_bus.valid),
   .rsp_ready (rsp_bus.ready),
   .rsp_red   (rsp_bus.red),
   .rsp_green (rsp_bus.green),
   .rsp_blue  (rsp_bus.blue)
);

// ===== sim/tb_hsv_to_rgb_converter.sv =====
module tb_hsv_to_rgb_converter;
   timeunit 1ns;
   timeprecision 1ps;

   import hsv2rgb_pkg::*;

   localparam int IDLE_LIMIT     = 4000;
   localparam int PHASE_COUNT    = 8;
   localparam int LEVELS_PER_SET = 154;
   localparam int DRAIN_CYCLES   = 8;
   localparam int EDGE_COUNT     = 19;

   typedef struct {
      logic [COLOR_W-1:0] red;
      logic [COLOR_W-1:0] green;
      logic [COLOR_W-1:0] blue;
   } rgb_beat_type;

   class color_scoreboard;
      logic [Q_W-1:0] sat_q18;
      logic [Q_W-1:0] bright_q18;
      rgb_beat_type   expected_colors[$];
      int             failures;
      int             checked;
      int             noted;

      function new();
         sat_q18    = SAT_RESET;
         bright_q18 = BRIGHT_RESET;
         failures   = 0;
         checked    = 0;
         noted      = 0;
      endfunction

      function void set_register(logic [CSR_IDX_W-1:0] idx, logic [Q_W-1:0] value);
         if (idx == CSR_SATURATION) begin
            sat_q18 = value;
         end else if (idx == CSR_BRIGHTNESS) begin
            bright_q18 = value;
         end
      endfunction

      // exact rational hsv math, common denominator 65536*MAX_LEVEL
      function rgb_beat_type predict_color(logic [LVL_W-1:0] level);
         longint unsigned m, lvl, x, rem, s, v, den;
         longint unsigned nv, np, nq, nt, cr, cg, cb;
         logic [SEC_W-1:0] sec;
         rgb_beat_type c;
         m   = MAX_LEVEL;
         lvl = level;
         if (lvl > m) begin
            lvl = m;
         end
         x   = lvl * 6;
         rem = x % m;
         if (x / m >= 6) begin
            // full-scale level wraps back to red
            sec = SEC_RED;
            rem = 0;
         end else begin
            sec = SEC_W'(x / m);
         end
         s   = (sat_q18 > Q_ONE) ? Q_ONE : sat_q18;
         v   = (bright_q18 > Q_ONE) ? Q_ONE : bright_q18;
         den = 65536 * m;
         nv  = v * 256 * m;
         np  = v * (256 - s) * m;
         nq  = v * (256 * m - s * rem);
         nt  = v * (256 * m - s * (m - rem));
         case (sec)
            SEC_RED: begin
               cr = nv; cg = nt; cb = np;
            end
            SEC_YELLOW: begin
               cr = nq; cg = nv; cb = np;
            end
            SEC_GREEN: begin
               cr = np; cg = nv; cb = nt;
            end
            SEC_CYAN: begin
               cr = np; cg = nq; cb = nv;
            end
            SEC_BLUE: begin
               cr = nt; cg = np; cb = nv;
            end
            default: begin
               cr = nv; cg = np; cb = nq;
            end
         endcase
         cr = (255 * cr) / den;
         cg = (255 * cg) / den;
         cb = (255 * cb) / den;
         c.red   = (cr > 255) ? 8'd255 : COLOR_W'(cr);
         c.green = (cg > 255) ? 8'd255 : COLOR_W'(cg);
         c.blue  = (cb > 255) ? 8'd255 : COLOR_W'(cb);
         return c;
      endfunction

      function void note_level(logic [LVL_W-1:0] level);
         expected_colors.push_back(predict_color(level));
         noted++;
      endfunction

      function void check_color(rgb_beat_type got);
         rgb_beat_type want;
         if (expected_colors.size() == 0) begin
            failures++;
            if (failures <= 10) begin
               $display("%0t: color beat with nothing pending: r=%0d g=%0d b=%0d",
                        $realtime, got.red, got.green, got.blue);
            end
            return;
         end
         want = expected_colors.pop_front();
         checked++;
         if (got.red !== want.red || got.green !== want.green || got.blue !== want.blue) begin
            failures++;
            if (failures <= 10) begin
               $display("%0t: color mismatch: expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
                        $realtime, want.red, want.green, want.blue,
                        got.red, got.green, got.blue);
            end
         end
      endfunction

      function int pending();
         return expected_colors.size();
      endfunction
   endclass

   logic clock;
   logic reset;
   logic csr_wr_en;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [Q_W-1:0] csr_wdata;

   int send_idle_pct;
   int recv_stall_pct;
   int idle_cycles;

   color_scoreboard sb = new();

   hsv2rgb_req_if req_bus ();
   hsv2rgb_rsp_if rsp_bus ();

   hsv_to_rgb_converter u_top (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus.sink),
      .rsp_bus   (rsp_bus.source),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // receiver backpressure
   always @(posedge clock) begin
      rsp_bus.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
   end

   // beat monitor and watchdog
   always @(posedge clock) begin
      rgb_beat_type got;
      if (!reset) begin
         if (req_bus.valid && req_bus.ready) begin
            sb.note_level(req_bus.level);
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            got.red   = rsp_bus.red;
            got.green = rsp_bus.green;
            got.blue  = rsp_bus.blue;
            sb.check_color(got);
         end
      end
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("watchdog: no beat for %0d cycles", IDLE_LIMIT);
         $display("tb_hsv_to_rgb_converter: done, errors");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic send_level(input logic [LVL_W-1:0] level);
      int gap;
      gap = 0;
      while (gap < 50 && $urandom_range(0, 99) < send_idle_pct) begin
         gap++;
      end
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.level <= level;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
   endtask

   // hold the sender until every pending color is back
   task automatic drain();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [Q_W-1:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      sb.set_register(idx, value);
      @(posedge clock);
   endtask

   initial begin
      logic [LVL_W-1:0] edge_levels[EDGE_COUNT] = '{0, 1, 42, 43, 44, 84, 85, 86, 127, 128,
                                                    169, 170, 171, 212, 213, 214, 253, 254,
                                                    255};
      logic [Q_W-1:0] sat_set[PHASE_COUNT]    = '{0, 256, 256, 511, 1, 300, 128, 0};
      logic [Q_W-1:0] bright_set[PHASE_COUNT] = '{256, 256, 0, 511, 255, 128, 205, 0};
      int r;

      reset          = 1'b1;
      csr_wr_en      = 1'b0;
      csr_index      = CSR_SATURATION;
      csr_wdata      = '0;
      req_bus.valid  = 1'b0;
      req_bus.level  = '0;
      rsp_bus.ready  = 1'b0;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      idle_cycles    = 0;

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // sector edges and the full-scale wrap at reset settings
      foreach (edge_levels[i]) begin
         send_level(edge_levels[i]);
      end

      sat_set[PHASE_COUNT-1]    = Q_W'($urandom_range(0, 511));
      bright_set[PHASE_COUNT-1] = Q_W'($urandom_range(0, 511));

      for (int ph = 0; ph < PHASE_COUNT; ph++) begin
         drain();
         write_csr(CSR_SATURATION, sat_set[ph]);
         write_csr(CSR_BRIGHTNESS, bright_set[ph]);
         case (ph % 4)
            0: begin
               send_idle_pct = 0;  recv_stall_pct = 0;
            end
            1: begin
               send_idle_pct = 62; recv_stall_pct = 0;
            end
            2: begin
               send_idle_pct = 0;  recv_stall_pct = 62;
            end
            default: begin
               send_idle_pct = 38; recv_stall_pct = 38;
            end
         endcase
         for (int i = 0; i < LEVELS_PER_SET; i++) begin
            if (i == LEVELS_PER_SET / 2) begin
               drain();
            end
            r = $urandom_range(0, 99);
            if (r < 5) begin
               send_level(LVL_W'(MAX_LEVEL));
            end else if (r < 10) begin
               send_level('0);
            end else begin
               send_level(LVL_W'($urandom_range(0, 255)));
            end
         end
      end

      drain();
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      repeat (16) @(posedge clock);

      if (sb.pending() != 0) begin
         $display("%0d colors never came back", sb.pending());
      end
      $display("covered %0d hue levels and %0d checked colors over %0d sat/bright settings,",
               sb.noted, sb.checked, PHASE_COUNT + 1);
      $display("including grey, black, full scale and over-range register values");
      if (sb.failures == 0 && sb.pending() == 0) begin
         $display("tb_hsv_to_rgb_converter: done, clean");
      end else begin
         $display("tb_hsv_to_rgb_converter: done, errors");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
design/hsv2rgb_pkg.sv
design/hsv2rgb_if.sv
design/hsv2rgb_sector.sv
design/hsv2rgb_blend.sv
design/hsv2rgb_scale.sv
design/hsv_to_rgb_converter.sv
design/hsv2rgb_checker.sv
sim/tb_hsv_to_rgb_converter.sv
